// ===== hw/rtl/sldf_pkg.sv =====
// Shared types and constants for the start-of-frame deframer with address match.
// Holds register indexes, phase codes, the result flag struct and the name word type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sldf_pkg;

	localparam int NAME_BYTES_DEF = 32;
	localparam int NAME_WORDS     = 4;
	localparam int WORD_W         = 64;
	localparam int CFG_ADDR_W     = 3;
	localparam int POS_W          = 7;
	localparam int LEN_W          = 32;
	localparam int PHASE_W        = 2;

	localparam logic [7:0] SOF_BYTE = 8'hA5;

	localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_NAME_W0 = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_NAME_W1 = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_NAME_W2 = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_NAME_W3 = 3'd3;

	localparam logic [PHASE_W-1:0] PH_HUNT    = 2'd0;
	localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd2;

	typedef logic [NAME_WORDS-1:0][WORD_W-1:0] name_words_t;

	typedef struct packed {
		logic in_frame;
		logic frame_first;
		logic frame_last;
		logic route_known;
		logic for_local;
	} res_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sof_length_deframer_with_address_match_unit.sv =====
// Start-of-frame, length-prefixed deframer with destination address match. Takes one byte
// per cycle unless stalled and returns one result per byte, in order, through an input
// register, then a result register; the frame state updates as a byte moves between the two.
// Bytes are dropped (in_frame low) until 0xA5, then a header of 2*NAME_BYTES+5 bytes and
// the little-endian length's payload pass. route_known/for_local rise on the last name byte.
// Depends on sldf_pkg, sldf_cfg_regs, sldf_tracker.
`timescale 1ns / 1ps
`default_nettype none

module sof_length_deframer_with_address_match_unit
	import sldf_pkg::*;
#(
	parameter int NAME_BYTES = NAME_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // [7:0] in_byte
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
	output logic                       m_axis_tlast,
	// [0] in_frame, [1] frame_first, [2] route_known, [3] for_local
	output logic [3:0]                 m_axis_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [WORD_W-1:0]     cfg_data
);

	name_words_t name_words;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	logic [7:0]  byte_s2;
	res_flags_t  res_s2;
	res_flags_t  res;
	logic        adv_s1;

	sldf_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.name_words(name_words)
	);

	sldf_tracker #(
		.NAME_BYTES(NAME_BYTES)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (adv_s1),
		.rx_byte   (byte_s1),
		.name_words(name_words),
		.res       (res)
	);

	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			byte_s2 <= byte_s1;
			res_s2  <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = byte_s2;
	assign m_axis_tlast  = res_s2.frame_last;
	assign m_axis_tuser  = {res_s2.for_local, res_s2.route_known,
		res_s2.frame_first, res_s2.in_frame};

	a_first_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.frame_first || res_s2.frame_last || res_s2.route_known)
		|-> res_s2.in_frame)
		else $error("frame marker on a dropped byte");

	a_local_needs_route: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.for_local |-> res_s2.route_known)
		else $error("for_local without route_known");

	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.frame_first && res_s2.frame_last))
		else $error("frame opened and closed on one byte");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(byte_s1))
		else $error("held input byte lost or changed");

	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2 && byte_s2 == $past(byte_s1))
		else $error("advanced byte not in result register");

endmodule

`default_nettype wire

// ===== hw/rtl/sldf_cfg_regs.sv =====
// Local endpoint name registers, written through the configuration channel.
// Depends on sldf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sldf_cfg_regs
	import sldf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [WORD_W-1:0]     cfg_data,
	output name_words_t                name_words
);

	name_words_t words_q;

	assign cfg_ready  = 1'b1;
	assign name_words = words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_LOCAL_NAME_W0: begin
					words_q[0] <= cfg_data;
				end
				REG_LOCAL_NAME_W1: begin
					words_q[1] <= cfg_data;
				end
				REG_LOCAL_NAME_W2: begin
					words_q[2] <= cfg_data;
				end
				REG_LOCAL_NAME_W3: begin
					words_q[3] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sldf_name_cmp.sv =====
// Destination name byte compare against the zero-terminated local name.
// Flags a mismatch at name byte k unless the local name already ended before k.
// Depends on sldf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sldf_name_cmp
	import sldf_pkg::*;
#(
	parameter int NAME_BYTES = NAME_BYTES_DEF,
	parameter int KW         = $clog2(NAME_BYTES)
) (
	input  wire name_words_t      name_words,
	input  wire logic [KW-1:0]    name_idx,
	input  wire logic [7:0]       rx_byte,
	output logic                  mismatch
);

	logic [NAME_WORDS*WORD_W-1:0] name_flat;
	logic [NAME_BYTES-1:0][7:0]   name_bytes;
	logic [NAME_BYTES-1:0]        byte_zero;
	logic                         ended_before;

	assign name_flat = name_words;

	always_comb begin
		for (int j = 0; j < NAME_BYTES; j++) begin
			name_bytes[j] = name_flat[8*j +: 8];
			byte_zero[j]  = (name_flat[8*j +: 8] == 8'h00);
		end
	end

	always_comb begin
		ended_before = 1'b0;
		for (int j = 0; j < NAME_BYTES; j++) begin
			if (KW'(j) < name_idx) begin
				ended_before = ended_before | byte_zero[j];
			end
		end
	end

	assign mismatch = !ended_before && (name_bytes[name_idx] != rx_byte);

endmodule

`default_nettype wire

// ===== hw/rtl/sldf_tracker.sv =====
// Frame state tracker: hunt, header and payload phases, length capture and route flags.
// State advances once per byte moved into the result register.
// Depends on sldf_pkg and sldf_name_cmp.
`timescale 1ns / 1ps
`default_nettype none

module sldf_tracker
	import sldf_pkg::*;
#(
	parameter int NAME_BYTES = NAME_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [7:0]  rx_byte,
	input  wire name_words_t name_words,
	output res_flags_t       res
);

	localparam int KW = $clog2(NAME_BYTES);
	localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(2 * NAME_BYTES + 4);
	localparam logic [POS_W-1:0] DST_FIRST = POS_W'(NAME_BYTES + 1);
	localparam logic [POS_W-1:0] DST_LAST  = POS_W'(2 * NAME_BYTES);
	localparam logic [POS_W-1:0] LEN_FIRST = POS_W'(2 * NAME_BYTES + 1);

	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic [LEN_W-1:0]   remain_q, remain_n;
	logic               match_q, match_n;
	logic               mismatch;
	logic [POS_W-1:0]   dst_off;
	logic [POS_W-1:0]   len_off;
	logic [LEN_W-1:0]   len_byte;

	assign dst_off = pos_q - DST_FIRST;
	assign len_off = pos_q - LEN_FIRST;

	sldf_name_cmp #(
		.NAME_BYTES(NAME_BYTES),
		.KW        (KW)
	) u_name_cmp (
		.name_words(name_words),
		.name_idx  (dst_off[KW-1:0]),
		.rx_byte   (rx_byte),
		.mismatch  (mismatch)
	);

	always_comb begin
		case (len_off[1:0])
			2'd0:    len_byte = {24'h0, rx_byte};
			2'd1:    len_byte = {16'h0, rx_byte, 8'h0};
			2'd2:    len_byte = {8'h0, rx_byte, 16'h0};
			default: len_byte = {rx_byte, 24'h0};
		endcase
	end

	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		len_n    = len_q;
		remain_n = remain_q;
		match_n  = match_q;
		res      = '0;
		if (phase_q == PH_HEADER && pos_q != '0 && pos_q <= HDR_LAST) begin
			res.in_frame = 1'b1;
			if (pos_q >= DST_FIRST && pos_q <= DST_LAST && mismatch) begin
				match_n = 1'b0;
			end
			if (pos_q >= LEN_FIRST) begin
				len_n = len_q | len_byte;
			end
			if (pos_q >= DST_LAST) begin
				res.route_known = 1'b1;
				res.for_local   = match_n;
			end
			if (pos_q == HDR_LAST) begin
				pos_n = '0;
				if (len_n == '0) begin
					res.frame_last = 1'b1;
					phase_n        = PH_HUNT;
				end else begin
					remain_n = len_n;
					phase_n  = PH_PAYLOAD;
				end
			end else begin
				pos_n = pos_q + 1'b1;
			end
		end else if (phase_q == PH_PAYLOAD && remain_q != '0) begin
			res.in_frame    = 1'b1;
			res.route_known = 1'b1;
			res.for_local   = match_q;
			remain_n        = remain_q - 1'b1;
			if (remain_q == LEN_W'(1)) begin
				res.frame_last = 1'b1;
				phase_n        = PH_HUNT;
			end
		end else begin
			phase_n = PH_HUNT;
			pos_n   = '0;
			if (rx_byte == SOF_BYTE) begin
				res.in_frame    = 1'b1;
				res.frame_first = 1'b1;
				phase_n         = PH_HEADER;
				pos_n           = POS_W'(1);
				len_n           = '0;
				remain_n        = '0;
				match_n         = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			pos_q    <= '0;
			len_q    <= '0;
			remain_q <= '0;
			match_q  <= 1'b1;
		end else if (advance) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			len_q    <= len_n;
			remain_q <= remain_n;
			match_q  <= match_n;
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb_sof_length_deframer_with_address_match_unit.sv =====
// Testbench for sof_length_deframer_with_address_match_unit: drives byte streams of framed
// and noise requests with random stalls, tracks frame state and the address match alongside.
// Depends on sldf_pkg and the unit under test; needs no files or arguments.
`timescale 1ns / 1ps

module tb_sof_length_deframer_with_address_match_unit;
	import sldf_pkg::*;

	localparam int NB        = NAME_BYTES_DEF;
	localparam int HDR_LEN   = 2 * NB + 5;
	localparam int DST_FIRST = NB + 1;
	localparam int DST_LAST  = 2 * NB;
	localparam int LEN_FIRST = 2 * NB + 1;
	localparam int RANDOM_BYTES = 100;

	typedef enum int {DST_MATCH, DST_MISS, DST_RANDOM} dst_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		res_flags_t flags;
	} deframed_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;
	logic                  m_axis_tlast;
	logic [3:0]            m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [WORD_W-1:0]     cfg_data = '0;

	// frame tracker state
	name_words_t        name_w = '0;
	logic [PHASE_W-1:0] rx_phase = PH_HUNT;
	logic [POS_W-1:0]   hdr_pos = '0;
	logic [LEN_W-1:0]   pay_len = '0;
	logic [LEN_W-1:0]   pay_rem = '0;
	logic               dst_match = 1'b1;

	logic [7:0] rx_q[$];
	deframed_t  deframed_q[$];
	int         mismatch_cnt = 0;
	int         byte_cnt = 0;
	bit         idle_on = 1'b0;
	int         src_gap = 0;
	int         sink_gap = 0;

	sof_length_deframer_with_address_match_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] local_byte(input int k);
		return name_w[k / 8][8 * (k % 8) +: 8];
	endfunction

	// index of the terminating zero of the local name, NB if there is none
	function automatic int local_len();
		int k;
		for (k = 0; k < NB; k++) begin
			if (local_byte(k) == 8'h00) return k;
		end
		return NB;
	endfunction

	function automatic deframed_t track_byte(input logic [7:0] b);
		deframed_t r;
		int        k;
		r = '0;
		r.data = b;
		if (rx_phase == PH_HEADER && hdr_pos >= 1 && hdr_pos < HDR_LEN) begin
			r.flags.in_frame = 1'b1;
			if (hdr_pos >= DST_FIRST && hdr_pos <= DST_LAST) begin
				k = hdr_pos - DST_FIRST;
				if (dst_match && local_len() >= k && local_byte(k) != b) dst_match = 1'b0;
			end
			if (hdr_pos >= LEN_FIRST)
				pay_len = pay_len | (LEN_W'(b) << (8 * ((hdr_pos - LEN_FIRST) % 4)));
			if (hdr_pos >= DST_LAST) begin
				r.flags.route_known = 1'b1;
				r.flags.for_local = dst_match;
			end
			if (hdr_pos == HDR_LEN - 1) begin
				hdr_pos = '0;
				if (pay_len == '0) begin
					r.last = 1'b1;
					rx_phase = PH_HUNT;
				end else begin
					pay_rem = pay_len;
					rx_phase = PH_PAYLOAD;
				end
			end else begin
				hdr_pos = hdr_pos + 1'b1;
			end
		end else if (rx_phase == PH_PAYLOAD && pay_rem != '0) begin
			r.flags.in_frame = 1'b1;
			r.flags.route_known = 1'b1;
			r.flags.for_local = dst_match;
			pay_rem = pay_rem - 1'b1;
			if (pay_rem == '0) begin
				r.last = 1'b1;
				rx_phase = PH_HUNT;
			end
		end else begin
			rx_phase = PH_HUNT;
			hdr_pos = '0;
			if (b == SOF_BYTE) begin
				r.flags.in_frame = 1'b1;
				r.flags.frame_first = 1'b1;
				rx_phase = PH_HEADER;
				hdr_pos = 1;
				pay_len = '0;
				pay_rem = '0;
				dst_match = 1'b1;
			end
		end
		return r;
	endfunction

	// driver: one request per handshake, random hold-offs while idle_on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) deframed_q.push_back(track_byte(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (rx_q.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= rx_q.pop_front();
					if (idle_on && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 11);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		deframed_t got;
		deframed_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.data = m_axis_tdata;
				got.last = m_axis_tlast;
				got.flags.in_frame = m_axis_tuser[0];
				got.flags.frame_first = m_axis_tuser[1];
				got.flags.route_known = m_axis_tuser[2];
				got.flags.for_local = m_axis_tuser[3];
				if (deframed_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: unexpected result byte=%h last=%b user=%b", $realtime,
							got.data, got.last, m_axis_tuser);
					mismatch_cnt++;
				end else begin
					want = deframed_q.pop_front();
					if (got !== want) begin
						if (mismatch_cnt < 10)
							$display({"%0t: mismatch byte %h/%h last %b/%b in_frame %b/%b",
								" first %b/%b known %b/%b local %b/%b (expected/actual)"},
								$realtime, want.data, got.data, want.last, got.last,
								want.flags.in_frame, got.flags.in_frame,
								want.flags.frame_first, got.flags.frame_first,
								want.flags.route_known, got.flags.route_known,
								want.flags.for_local, got.flags.for_local);
						mismatch_cnt++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 11);
			end
		end
	end

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx <= REG_LOCAL_NAME_W3) name_w[idx] = val;
	endtask

	task automatic load_name_words(input name_words_t w);
		write_reg(REG_LOCAL_NAME_W0, w[0]);
		write_reg(REG_LOCAL_NAME_W1, w[1]);
		write_reg(REG_LOCAL_NAME_W2, w[2]);
		write_reg(REG_LOCAL_NAME_W3, w[3]);
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_LOCAL_NAME_W3 + CFG_ADDR_W'($urandom_range(1, 4)),
				{$urandom, $urandom});
	endtask

	// nonzero bytes before zpos, a zero at zpos, garbage after it
	task automatic load_local_name(input int zpos);
		name_words_t w;
		int          k;
		for (k = 0; k < NB; k++) begin
			if (k < zpos) w[k / 8][8 * (k % 8) +: 8] = 8'($urandom_range(1, 255));
			else if (k == zpos) w[k / 8][8 * (k % 8) +: 8] = 8'h00;
			else w[k / 8][8 * (k % 8) +: 8] = 8'($urandom);
		end
		load_name_words(w);
	endtask

	task automatic queue_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom);
			if (b == SOF_BYTE) b = ~SOF_BYTE;
			rx_q.push_back(b);
			byte_cnt++;
		end
	endtask

	task automatic queue_frame(input logic [LEN_W-1:0] len, input dst_kind_t kind);
		int         zpos;
		int         miss_at;
		int         k;
		logic [7:0] db;
		zpos = local_len();
		miss_at = $urandom_range(0, (zpos < NB) ? zpos : NB - 1);
		rx_q.push_back(SOF_BYTE);
		repeat (NB) rx_q.push_back(8'($urandom));
		for (k = 0; k < NB; k++) begin
			if (kind == DST_RANDOM || k > zpos) begin
				db = 8'($urandom);
			end else begin
				db = local_byte(k);
				if (kind == DST_MISS && k == miss_at) db = db ^ 8'($urandom_range(1, 255));
			end
			rx_q.push_back(db);
		end
		for (k = 0; k < 4; k++) rx_q.push_back(len[8 * k +: 8]);
		repeat (len) rx_q.push_back(8'($urandom));
		byte_cnt += HDR_LEN + int'(len);
	endtask

	task automatic queue_random_frames(input int n);
		logic [LEN_W-1:0] len;
		repeat (n) begin
			queue_noise($urandom_range(0, 3));
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 24);
			queue_frame(len, dst_kind_t'($urandom_range(0, 2)));
		end
	endtask

	// hold the source until every expected result has come back
	task automatic drain();
		while (rx_q.size() != 0 || s_axis_tvalid || deframed_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int rand_base;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		// dropped bytes at the extremes, then frames under the empty local name
		rx_q.push_back(8'h00);
		rx_q.push_back(8'hFF);
		rx_q.push_back(8'h7F);
		rx_q.push_back(8'h80);
		rx_q.push_back(~SOF_BYTE);
		byte_cnt += 5;
		queue_frame(0, DST_MATCH);
		queue_frame(1, DST_MISS);
		queue_frame(3, DST_RANDOM);
		drain();

		load_name_words({NAME_WORDS{{WORD_W{1'b1}}}});
		queue_frame(2, DST_MATCH);
		queue_frame(0, DST_MISS);
		queue_frame(5, DST_MATCH);
		drain();

		load_local_name(0);
		queue_frame(0, DST_MATCH);
		queue_frame(1, DST_MISS);
		queue_frame(260, DST_MATCH);
		drain();

		load_local_name(NB - 1);
		queue_frame(4, DST_MATCH);
		queue_frame(1, DST_MISS);
		drain();

		load_name_words('0);
		queue_random_frames(2);
		drain();

		rand_base = byte_cnt;
		while (byte_cnt - rand_base < RANDOM_BYTES) begin
			load_local_name($urandom_range(0, NB));
			queue_random_frames($urandom_range(1, 2));
			drain();
		end

		// closing stretch with no idling on either side
		idle_on = 1'b0;
		load_local_name($urandom_range(0, NB));
		queue_random_frames(2);
		drain();

		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && deframed_q.size() == 0) begin
			$display("sof_length_deframer_with_address_match_unit regression: pass");
		end else begin
			$display("sof_length_deframer_with_address_match_unit regression: fail");
		end
		$finish;
	end

	initial begin
		#(12 * 500000);
		$display("sof_length_deframer_with_address_match_unit regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/sldf_pkg.sv
hw/rtl/sldf_cfg_regs.sv
hw/rtl/sldf_name_cmp.sv
hw/rtl/sldf_tracker.sv
hw/rtl/sof_length_deframer_with_address_match_unit.sv
verif/tb_sof_length_deframer_with_address_match_unit.sv
